// ===== src/flow_counter_cache_unit_assert.svh =====
// Assertion macros for the flow counter cache.
`ifndef FLOW_COUNTER_CACHE_UNIT_ASSERT_SVH
`define FLOW_COUNTER_CACHE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FCC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== src/fcc_pkg.sv =====
package fcc_pkg;
   localparam int TableDepth = 64;
   localparam int IdxW = $clog2(TableDepth);
   localparam int OccW = $clog2(TableDepth + 1);
   localparam int NearFullShift = 3;
   localparam logic [15:0] LfsrTaps = 16'hB400;
   localparam logic [15:0] SeedReset = 16'd44257;
   localparam logic [6:0] MaxReset = 7'd64;
   localparam logic CsrMaxEntries = 1'b0;
   localparam logic CsrVictimSeed = 1'b1;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_req;      // capture request beat
      logic scan_clear;    // reset scan index
      logic scan_step;     // compare entry and advance
      logic mod_start;     // start victim remainder
      logic mod_step;      // one restoring step
      logic rd_slot;       // read table row at chosen slot
      logic wr_packet;     // write updated row
      logic wr_export;     // clear counters of exported row
      logic rsp_load;      // load result register
      logic rsp_ignore;    // result is all zero
      logic lfsr_adv;      // advance victim LFSR
   } fcc_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_export;
      logic is_ipv6;
      logic scan_hit;
      logic scan_done;
      logic has_room;
      logic mod_done;
   } fcc_sts_type;
endpackage

// ===== src/flow_counter_cache_unit.sv =====
// Flow counter cache: one item at a time, one result per item.
// Every key path scans the occupied entries before it reads and writes a row;
// an eviction also runs the victim remainder first. An export and an IPv6
// packet skip the scan. The next beat is taken in the cycle after the result is
// loaded, and a result is not loaded while the previous one is still held back.
// Synchronous active-high reset clears valid and dirty bits, occupancy, CSRs and
// the scan, remainder and response flags; memories and data registers hold no reset.
module flow_counter_cache_unit (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [47:0] req_src_mac,
   input  logic [47:0] req_dst_mac,
   input  logic req_is_ipv6,
   input  logic req_from_client,
   input  logic [15:0] req_pkt_len,
   input  logic [15:0] req_service_id,
   input  logic [5:0] req_entry_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [5:0] rsp_slot,
   output logic rsp_is_new,
   output logic rsp_evicted,
   output logic rsp_flush_request,
   output logic rsp_service_changed,
   output logic rsp_record_valid,
   output logic [31:0] rsp_in_packets,
   output logic [63:0] rsp_in_octets,
   output logic [31:0] rsp_out_packets,
   output logic [63:0] rsp_out_octets,
   output logic [15:0] rsp_service_out
);
   import fcc_pkg::*;
   `include "flow_counter_cache_unit_assert.svh"

   fcc_cmd_type cmd;
   fcc_sts_type sts;
   logic rsp_busy;
   logic [OccW-1:0] occupancy;

   fcc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_busy, .sts, .cmd
   );

   fcc_datapath u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_op, .req_src_ip, .req_dst_ip, .req_src_port, .req_dst_port,
      .req_src_mac, .req_dst_mac, .req_is_ipv6, .req_from_client,
      .req_pkt_len, .req_service_id, .req_entry_index,
      .rsp_valid, .rsp_ready, .rsp_busy, .rsp_slot, .rsp_is_new,
      .rsp_evicted, .rsp_flush_request, .rsp_service_changed,
      .rsp_record_valid, .rsp_in_packets, .rsp_in_octets, .rsp_out_packets,
      .rsp_out_octets, .rsp_service_out, .occupancy
   );

   `FCC_ASSERT_IMP(a_occ_max, clock, reset, 1'b1, occupancy <= OccW'(TableDepth))
   `FCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot))
   `FCC_ASSERT_IMP(a_evict_new, clock, reset, rsp_valid && rsp_evicted, rsp_is_new)
   `FCC_ASSERT_IMP(a_rec_export, clock, reset, rsp_valid && rsp_record_valid,
                   !rsp_is_new && !rsp_evicted)
endmodule

// ===== src/fcc_ctrl.sv =====
module fcc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic rsp_busy,
   input  fcc_pkg::fcc_sts_type sts,
   output fcc_pkg::fcc_cmd_type cmd
);
   import fcc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_MISS, S_MOD, S_READ, S_WAIT, S_WRITE, S_EXPORT,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_export) begin
               cmd.rd_slot = 1'b1;
               state_in = S_EXPORT;
            end else if (sts.is_ipv6) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_hit) begin
               cmd.rd_slot = 1'b1;
               state_in = S_WAIT;
            end else if (sts.scan_done) begin
               state_in = S_MISS;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_MISS: begin
            if (sts.has_room) begin
               // With no remainder running, a step claims the next free slot.
               cmd.mod_step = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.lfsr_adv = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            // The LFSR has advanced by now; start the remainder.
            cmd.mod_start = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.mod_done) begin
               cmd.rd_slot = 1'b1;
               state_in = S_WAIT;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_packet = 1'b1;
            state_in = S_RESULT;
         end
         S_EXPORT: begin
            cmd.wr_export = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_busy) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_ignore = sts.is_ipv6 && !sts.is_export;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== src/fcc_datapath.sv =====
module fcc_datapath (
   input  logic clock,
   input  logic reset,
   input  fcc_pkg::fcc_cmd_type cmd,
   output fcc_pkg::fcc_sts_type sts,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_op,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [47:0] req_src_mac,
   input  logic [47:0] req_dst_mac,
   input  logic req_is_ipv6,
   input  logic req_from_client,
   input  logic [15:0] req_pkt_len,
   input  logic [15:0] req_service_id,
   input  logic [5:0] req_entry_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_busy,
   output logic [5:0] rsp_slot,
   output logic rsp_is_new,
   output logic rsp_evicted,
   output logic rsp_flush_request,
   output logic rsp_service_changed,
   output logic rsp_record_valid,
   output logic [31:0] rsp_in_packets,
   output logic [63:0] rsp_in_octets,
   output logic [31:0] rsp_out_packets,
   output logic [63:0] rsp_out_octets,
   output logic [15:0] rsp_service_out,
   output logic [fcc_pkg::OccW-1:0] occupancy
);
   import fcc_pkg::*;

   localparam int KeyW = 64 + 32 + 48 + 48;
   localparam int CntW = 32 + 64 + 32 + 64 + 16;

   logic [KeyW-1:0] key_mem [TableDepth];
   logic [CntW-1:0] cnt_mem [TableDepth];
   logic [TableDepth-1:0] valid_ff, dirty_ff;

   logic [6:0] max_ff;
   logic [15:0] seed_ff, lfsr_ff;
   logic [OccW-1:0] occ_ff;

   logic op_ff, ipv6_ff, client_ff;
   logic [KeyW-1:0] key_ff;
   logic [15:0] len_ff, svc_ff;
   logic [5:0] index_ff;

   logic [OccW-1:0] scan_ff;
   logic [KeyW-1:0] key_rd_ff;
   logic hit_ff;
   logic [IdxW-1:0] slot_ff;
   logic new_ff, evict_ff;
   logic [CntW-1:0] cnt_rd_ff;

   // Restoring remainder of the LFSR by the occupancy, one bit a step.
   logic [OccW:0] rem_ff;
   logic [15:0] quo_ff;
   logic [4:0] mod_cnt_ff;
   logic mod_busy_ff;

   logic [OccW-1:0] lim;
   logic [OccW:0] rem_shift;

   // The scan index runs one ahead of the compared row: key_rd_ff holds
   // the row addressed in the previous cycle.
   logic scan_cmp_ff;
   logic [IdxW-1:0] cmp_idx_ff;

   always_comb begin
      if (max_ff == 7'd0) begin
         lim = OccW'(1);
      end else if (32'(max_ff) > TableDepth) begin
         lim = OccW'(TableDepth);
      end else begin
         lim = OccW'(max_ff);
      end
   end

   assign rem_shift = {rem_ff[OccW-1:0], quo_ff[15]};
   assign occupancy = occ_ff;

   assign sts.is_export = op_ff;
   assign sts.is_ipv6 = ipv6_ff;
   assign sts.scan_hit = hit_ff;
   // The last compare is still pending while scan_cmp_ff is set.
   assign sts.scan_done = (scan_ff >= occ_ff) && !scan_cmp_ff && !hit_ff;
   assign sts.has_room = occ_ff < lim;
   assign sts.mod_done = !mod_busy_ff;

   // Packet update arithmetic on the row read back.
   logic [31:0] ip_c, op_c;
   logic [63:0] ib_c, ob_c;
   logic [15:0] sv_c, sv_new;
   logic changed_c;
   logic [OccW-1:0] occ_new;
   logic [OccW+1:0] near_sum;
   logic [CntW-1:0] row_new;

   always_comb begin
      {ip_c, ib_c, op_c, ob_c, sv_c} = new_ff ? '0 : cnt_rd_ff;
      changed_c = (svc_ff != 16'd0) && (sv_c != 16'd0) && (sv_c != svc_ff);
      sv_new = (svc_ff != 16'd0) ? svc_ff : sv_c;
      if (client_ff) begin
         ip_c = ip_c + 32'd1;
         ib_c = ib_c + 64'(len_ff);
      end else begin
         op_c = op_c + 32'd1;
         ob_c = ob_c + 64'(len_ff);
      end
      row_new = {ip_c, ib_c, op_c, ob_c, sv_new};
      occ_new = occ_ff;
      near_sum = (OccW+2)'(occ_new) + (OccW+2)'(occ_new >> NearFullShift);
   end

   logic [IdxW-1:0] scan_idx;
   assign scan_idx = scan_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_op;
         ipv6_ff <= req_is_ipv6;
         client_ff <= req_from_client;
         key_ff <= {req_src_ip, req_dst_ip, req_src_port, req_dst_port,
                    req_src_mac, req_dst_mac};
         len_ff <= req_pkt_len;
         svc_ff <= req_service_id;
         index_ff <= req_entry_index;
      end
      key_rd_ff <= key_mem[scan_idx];
      if (cmd.rd_slot) begin
         cnt_rd_ff <= cnt_mem[op_ff ? index_ff[IdxW-1:0] : slot_ff];
      end
      if (cmd.wr_packet) begin
         cnt_mem[slot_ff] <= row_new;
         if (new_ff) begin
            key_mem[slot_ff] <= key_ff;
         end
      end
      if (cmd.wr_export && valid_ff[index_ff[IdxW-1:0]] && dirty_ff[index_ff[IdxW-1:0]]) begin
         cnt_mem[index_ff[IdxW-1:0]] <= {{(CntW-16){1'b0}}, cnt_rd_ff[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         occ_ff <= '0;
         max_ff <= MaxReset;
         seed_ff <= SeedReset;
         lfsr_ff <= SeedReset;
         scan_ff <= '0;
         hit_ff <= 1'b0;
         scan_cmp_ff <= 1'b0;
         mod_busy_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CsrMaxEntries) begin
               max_ff <= csr_data[6:0];
            end else begin
               seed_ff <= csr_data;
               lfsr_ff <= (csr_data == 16'd0) ? 16'd1 : csr_data;
            end
         end
         if (cmd.lfsr_adv) begin
            lfsr_ff <= lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LfsrTaps) : (lfsr_ff >> 1);
         end
         if (cmd.scan_clear) begin
            scan_ff <= '0;
            hit_ff <= 1'b0;
            scan_cmp_ff <= 1'b0;
            new_ff <= 1'b0;
            evict_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (scan_cmp_ff && valid_ff[cmp_idx_ff] && key_rd_ff == key_ff) begin
               hit_ff <= 1'b1;
               slot_ff <= cmp_idx_ff;
            end else if (scan_ff < occ_ff) begin
               scan_ff <= scan_ff + OccW'(1);
               cmp_idx_ff <= scan_idx;
               scan_cmp_ff <= 1'b1;
            end else begin
               scan_cmp_ff <= 1'b0;
            end
         end
         if (cmd.mod_start) begin
            rem_ff <= '0;
            quo_ff <= lfsr_ff;
            mod_cnt_ff <= 5'd16;
            mod_busy_ff <= 1'b1;
            new_ff <= 1'b1;
            evict_ff <= 1'b1;
         end else if (cmd.mod_step && mod_busy_ff) begin
            if (rem_shift >= {1'b0, occ_ff}) begin
               rem_ff <= rem_shift - {1'b0, occ_ff};
            end else begin
               rem_ff <= rem_shift;
            end
            quo_ff <= quo_ff << 1;
            mod_cnt_ff <= mod_cnt_ff - 5'd1;
            if (mod_cnt_ff == 5'd1) begin
               mod_busy_ff <= 1'b0;
            end
         end else if (cmd.mod_step && !new_ff) begin
            // Free slot path: take the next slot.
            new_ff <= 1'b1;
            slot_ff <= occ_ff[IdxW-1:0];
            occ_ff <= occ_ff + OccW'(1);
         end
         if (cmd.rd_slot && evict_ff && !op_ff) begin
            slot_ff <= rem_ff[IdxW-1:0];
         end
         if (cmd.wr_packet) begin
            valid_ff[slot_ff] <= 1'b1;
            dirty_ff[slot_ff] <= 1'b1;
         end
         if (cmd.wr_export) begin
            dirty_ff[index_ff[IdxW-1:0]] <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   logic exp_ok_ff;
   logic chg_ff, near_ff;
   always_ff @(posedge clock) begin
      if (cmd.wr_export) begin
         exp_ok_ff <= valid_ff[index_ff[IdxW-1:0]] && dirty_ff[index_ff[IdxW-1:0]];
      end
      if (cmd.wr_packet) begin
         chg_ff <= changed_c;
         near_ff <= (OccW+2)'(lim) < near_sum;
      end
   end

   assign rsp_busy = rsp_valid && !rsp_ready;

   logic [5:0] slot_ff_ext;
   assign slot_ff_ext = 6'(slot_ff);

   logic [5:0] rsp_slot_ff;
   logic rsp_new_ff, rsp_evict_ff, rsp_rec_ff, rsp_chg_ff, rsp_near_ff;
   logic [CntW-1:0] rsp_cnt_ff;

   // Result fields only change when a new beat is loaded.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_slot_ff <= cmd.rsp_ignore ? 6'd0 : (op_ff ? index_ff : slot_ff_ext);
         rsp_new_ff <= !cmd.rsp_ignore && !op_ff && new_ff;
         rsp_evict_ff <= !cmd.rsp_ignore && !op_ff && evict_ff;
         rsp_chg_ff <= !cmd.rsp_ignore && !op_ff && chg_ff;
         rsp_near_ff <= !cmd.rsp_ignore && !op_ff && near_ff;
         rsp_rec_ff <= op_ff && exp_ok_ff;
         rsp_cnt_ff <= (op_ff && exp_ok_ff) ? cnt_rd_ff : '0;
      end
   end

   assign rsp_slot = rsp_slot_ff;
   assign rsp_is_new = rsp_new_ff;
   assign rsp_evicted = rsp_evict_ff;
   assign rsp_service_changed = rsp_chg_ff;
   assign rsp_flush_request = rsp_near_ff;
   assign rsp_record_valid = rsp_rec_ff;
   assign {rsp_in_packets, rsp_in_octets, rsp_out_packets, rsp_out_octets,
           rsp_service_out} = rsp_cnt_ff;
   logic unused_seed;
   assign unused_seed = ^seed_ff ^ occ_new[0];
endmodule
